>>> hw/rtl/ism_pkg.sv
// Package with shared constants and types for the interval sort and merge block.
package ism_pkg;

    localparam int MAX_INTERVALS_DEF = 64;
    localparam int VALUE_WIDTH_DEF   = 16;
    localparam int OUT_WIDTH         = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_MRG_RD,
        ST_MRG,
        ST_EMIT
    } state_t;

endpackage

>>> hw/rtl/interval_sort_and_merge_top.sv
// Top level of the interval sort and merge block.
//
// Intervals arrive one word at a time and are inserted into a start/end
// memory pair kept sorted by start; an equal start goes after the earlier
// ones. Insertion walks down from the fill point, one memory read and one
// write per cycle, moving each larger entry up one place, and the block
// takes one word at a time. A word flagged last starts a merge pass that
// reads the sorted entries in order, one per cycle, and sends each merged
// interval out when a later start lies past the running end; the pass stalls
// while an output word waits. Words beyond MAX_INTERVALS are dropped and
// overflow is set on every result of that set. The memories need no
// clearing: only written entries are read.
module interval_sort_and_merge_top #(
    parameter int MAX_INTERVALS = ism_pkg::MAX_INTERVALS_DEF,
    parameter int VALUE_WIDTH   = ism_pkg::VALUE_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // range_start [15:0], range_end [31:16]
    input  logic        s_tlast,   // final_item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // merged_start [15:0], merged_end [31:16]
    output logic        m_tlast,   // last_merged
    output logic        m_tuser    // overflow
);
    localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int CW = $clog2(MAX_INTERVALS + 1);
    localparam int VW = VALUE_WIDTH;
    localparam int OW = ism_pkg::OUT_WIDTH;

    logic [VW-1:0] start_mem [MAX_INTERVALS];
    logic [VW-1:0] end_mem   [MAX_INTERVALS];

    ism_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic          drop_reg, drop_next;
    logic          fin_reg, fin_next;
    logic [VW-1:0] ns_reg, ns_next, ne_reg, ne_next;
    logic [VW-1:0] cs_reg, cs_next, ce_reg, ce_next;
    logic [VW-1:0] rd_s, rd_e;
    logic          out_valid_reg, out_valid_next;
    logic [VW-1:0] os_reg, os_next, oe_reg, oe_next;
    logic          olast_reg, olast_next, oovf_reg, oovf_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [VW-1:0] wdat_s, wdat_e;

    always_ff @(posedge aclk) begin
        if (we) begin
            start_mem[waddr] <= wdat_s;
            end_mem[waddr]   <= wdat_e;
        end
        rd_s <= start_mem[raddr];
        rd_e <= end_mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ism_pkg::ST_IDLE;
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
        pos_reg   <= pos_next;
        fin_reg   <= fin_next;
        ns_reg    <= ns_next;
        ne_reg    <= ne_next;
        cs_reg    <= cs_next;
        ce_reg    <= ce_next;
        os_reg    <= os_next;
        oe_reg    <= oe_next;
        olast_reg <= olast_next;
        oovf_reg  <= oovf_next;
    end

    logic out_free;
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        drop_next  = drop_reg;
        fin_next   = fin_reg;
        ns_next    = ns_reg;
        ne_next    = ne_reg;
        cs_next    = cs_reg;
        ce_next    = ce_reg;
        os_next    = os_reg;
        oe_next    = oe_reg;
        olast_next = olast_reg;
        oovf_next  = oovf_reg;
        out_valid_next = out_valid_reg && !m_tready;
        s_tready   = 1'b0;
        we         = 1'b0;
        waddr      = pos_reg[AW-1:0];
        raddr      = pos_reg[AW-1:0];
        wdat_s     = ns_reg;
        wdat_e     = ne_reg;
        case (state_reg)
            ism_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                raddr    = AW'(count_reg - CW'(1));
                if (s_tvalid) begin
                    fin_next = s_tlast;
                    ns_next  = VW'(s_tdata[15:0]);
                    ne_next  = VW'(s_tdata[31:16]);
                    pos_next = count_reg;
                    if (count_reg == CW'(MAX_INTERVALS)) begin
                        drop_next  = 1'b1;
                        state_next = s_tlast ? ism_pkg::ST_MRG_RD : ism_pkg::ST_IDLE;
                        pos_next   = '0;
                    end else begin
                        count_next = count_reg + CW'(1);
                        state_next = ism_pkg::ST_SHIFT;
                    end
                end
            end
            ism_pkg::ST_SHIFT: begin
                // rd holds entry pos-1 when pos > 0.
                we = 1'b1;
                if (pos_reg != '0 && rd_s > ns_reg) begin
                    wdat_s   = rd_s;
                    wdat_e   = rd_e;
                    pos_next = pos_reg - CW'(1);
                    raddr    = AW'(pos_reg - CW'(2));
                    // The entry below is read now, so it is ready next cycle.
                end else begin
                    state_next = fin_reg ? ism_pkg::ST_MRG_RD : ism_pkg::ST_IDLE;
                    pos_next   = '0;
                    raddr      = '0;
                end
            end
            ism_pkg::ST_MRG_RD: begin
                raddr      = '0;
                pos_next   = CW'(1);
                state_next = ism_pkg::ST_MRG;
                cs_next    = '0;
            end
            ism_pkg::ST_MRG: begin
                // rd holds entry pos-1.
                raddr = pos_reg[AW-1:0];
                if (pos_reg == CW'(1)) begin
                    cs_next  = rd_s;
                    ce_next  = rd_e;
                    pos_next = pos_reg + CW'(1);
                    if (count_reg == CW'(1)) state_next = ism_pkg::ST_EMIT;
                end else if (rd_s <= ce_reg) begin
                    if (rd_e > ce_reg) ce_next = rd_e;
                    pos_next = pos_reg + CW'(1);
                    if (pos_reg == count_reg) state_next = ism_pkg::ST_EMIT;
                end else if (out_free) begin
                    out_valid_next = 1'b1;
                    os_next    = cs_reg;
                    oe_next    = ce_reg;
                    olast_next = 1'b0;
                    oovf_next  = drop_reg;
                    cs_next    = rd_s;
                    ce_next    = rd_e;
                    pos_next   = pos_reg + CW'(1);
                    if (pos_reg == count_reg) state_next = ism_pkg::ST_EMIT;
                end else begin
                    raddr = AW'(pos_reg - CW'(1));
                end
            end
            ism_pkg::ST_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    os_next    = cs_reg;
                    oe_next    = ce_reg;
                    olast_next = 1'b1;
                    oovf_next  = drop_reg;
                    count_next = '0;
                    drop_next  = 1'b0;
                    state_next = ism_pkg::ST_IDLE;
                end
            end
            default: state_next = ism_pkg::ST_IDLE;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {OW'(oe_reg), OW'(os_reg)};
    assign m_tlast  = olast_reg;
    assign m_tuser  = oovf_reg;
endmodule
